// ===== rtl/itoa_pkg.sv =====
// itoa_pkg: shared types and character constants for the integer to ASCII formatter.
// No dependencies; imported by itoa_conv, itoa_emit and the top level.
package itoa_pkg;

    localparam int ND_W = 5;   // digit count, up to twenty decimal digits
    localparam int CH_W = 8;   // ASCII character
    localparam int WD_W = 6;   // field width

    // format of the number being printed, latched by the emitter
    typedef struct packed {
        logic            neg;
        logic            zpad;
        logic [WD_W-1:0] width;
    } t_fmt;

    // conversion unit status towards the emitter
    typedef struct packed {
        logic            done;
        logic [ND_W-1:0] nd;
        logic [3:0]      digit;
    } t_conv_stat;

    localparam logic [CH_W-1:0] HEX_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CHAR_SPACE = 8'h20;

endpackage

// ===== rtl/integer_to_ascii_formatter.sv =====
// integer_to_ascii_formatter: top level, input decode and sign handling.
// Depends on itoa_pkg, itoa_conv and itoa_emit.

// One input transaction carries a number and its format; the block answers with
// one output transaction per ASCII character, most significant digit first, and
// o_last marks the final character. Only the low VALUE_BITS bits of i_value are
// used. Decimal or lower-case hex is chosen by i_hex_base; with i_signed_mode a
// negative value prints '-' and its magnitude (the most negative value exactly).
// Zero prints as a single '0'. i_min_width (saturated at WIDTH_LIMIT) sets the
// minimum field width: with i_zero_pad the '-' comes first and zeros fill the
// width after it, otherwise spaces come ahead of the sign and digits.
// Timing: the magnitude is converted one bit per clock through a shift-and-add-3
// digit register (no add-3 in hex), then leading zeros are stripped one digit
// per clock, then characters leave at one per clock while the output is not
// stalled. A new item is taken as soon as the previous one's last character
// sits in the output register.
module integer_to_ascii_formatter #(
    parameter int WIDTH_LIMIT = 63,
    parameter int VALUE_BITS  = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [63:0]                i_value,
    input  logic                       i_hex_base,
    input  logic                       i_signed_mode,
    input  logic [itoa_pkg::WD_W-1:0]  i_min_width,
    input  logic                       i_zero_pad,
    // output channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [itoa_pkg::CH_W-1:0]  o_ch,
    output logic                       o_last
);
    import itoa_pkg::*;

    // decimal digits of 2^VALUE_BITS - 1; 1233/4096 approximates log10(2)
    localparam int DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam logic [WD_W-1:0] LIMIT = WD_W'(WIDTH_LIMIT);

    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic                  start;
    logic                  busy;
    logic                  take;
    t_fmt                  fmt;
    t_conv_stat            stat;

    assign v   = i_value[VALUE_BITS-1:0];
    assign neg = i_signed_mode && v[VALUE_BITS-1];
    // two's complement magnitude; the most negative value maps onto itself
    assign mag = neg ? (~v + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v;

    assign fmt.neg   = neg;
    assign fmt.zpad  = i_zero_pad;
    assign fmt.width = (i_min_width > LIMIT) ? LIMIT : i_min_width;

    // a transaction is accepted once the emitter has loaded its last character into the output register
    assign o_stall = busy;
    assign start   = i_valid && !busy;

    itoa_conv #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mag   (mag),
        .i_hex   (i_hex_base),
        .i_take  (take),
        .o_stat  (stat)
    );

    itoa_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_fmt   (fmt),
        .i_stat  (stat),
        .o_take  (take),
        .o_busy  (busy),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ch    (o_ch),
        .o_last  (o_last)
    );

endmodule

// ===== rtl/itoa_conv.sv =====
// itoa_conv: bit-serial binary to BCD (shift and add three) or hex digit register,
// with serial leading-zero strip. Depends on itoa_pkg.
module itoa_conv #(
    parameter int VALUE_BITS = 64,
    parameter int DIGITS     = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_BITS-1:0]  i_mag,
    input  logic                   i_hex,
    input  logic                   i_take,
    output itoa_pkg::t_conv_stat   o_stat
);
    import itoa_pkg::*;

    localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int BCD_W = 4 * DIGITS;

    typedef enum logic [1:0] {C_IDLE, C_SHIFT, C_STRIP, C_READY} t_cstate;

    t_cstate               r_state;
    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [CNT_W-1:0]      r_cnt;
    logic [ND_W-1:0]       r_nd;
    logic                  r_hex;

    logic [BCD_W-1:0]      n_corr;
    logic [3:0]            top_digit;

    // in decimal mode, add three to every digit of five or more, ahead of the shift
    always_comb begin
        logic [3:0] dig;
        for (int d = 0; d < DIGITS; d++) begin
            dig = r_bcd[4*d +: 4];
            if (!r_hex && dig >= 4'd5) begin
                dig = dig + 4'd3;
            end
            n_corr[4*d +: 4] = dig;
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else if (i_start) begin
            r_state <= C_SHIFT;
            r_bin   <= i_mag;
            r_bcd   <= '0;
            r_cnt   <= CNT_W'(VALUE_BITS - 1);
            r_hex   <= i_hex;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    r_state <= C_IDLE;
                end
                C_SHIFT: begin
                    r_bcd <= {n_corr[BCD_W-2:0], r_bin[VALUE_BITS-1]};
                    r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= C_STRIP;
                        r_nd    <= ND_W'(DIGITS);
                    end
                end
                C_STRIP: begin
                    // drop leading zeros, always keep one digit
                    if (top_digit == 4'd0 && r_nd > ND_W'(1)) begin
                        r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_nd  <= r_nd - 1'b1;
                    end else begin
                        r_state <= C_READY;
                    end
                end
                C_READY: begin
                    if (i_take) begin
                        r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_nd  <= r_nd - 1'b1;
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_stat.done  = (r_state == C_READY);
    assign o_stat.nd    = r_nd;
    assign o_stat.digit = top_digit;

endmodule

// ===== rtl/itoa_emit.sv =====
// itoa_emit: sign/padding sequencer and output register, one character per transaction.
// Depends on itoa_pkg; takes digits from itoa_conv.
module itoa_emit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  itoa_pkg::t_fmt              i_fmt,
    input  itoa_pkg::t_conv_stat        i_stat,
    output logic                        o_take,
    output logic                        o_busy,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [itoa_pkg::CH_W-1:0]   o_ch,
    output logic                        o_last
);
    import itoa_pkg::*;

    typedef enum logic [2:0] {E_IDLE, E_WAIT, E_LEAD, E_PAD, E_SIGN, E_DIGIT} t_estate;

    t_estate         r_state;
    t_fmt            r_fmt;
    logic [WD_W-1:0] r_pad;
    logic [ND_W-1:0] r_nd;
    logic            r_o_valid;
    logic [CH_W-1:0] r_ch;
    logic            r_last;

    logic            adv;
    logic            emit_now;
    logic            lead_sign;
    logic            mid_sign;
    logic [WD_W-1:0] w_adj;
    logic [WD_W-1:0] count;
    logic [WD_W-1:0] pad_calc;

    assign adv       = !r_o_valid || !i_stall;
    // a character is loaded into the output register this cycle
    assign emit_now  = adv && (r_state != E_IDLE) && (r_state != E_WAIT);
    assign lead_sign = r_fmt.neg && r_fmt.zpad;
    assign mid_sign  = r_fmt.neg && !r_fmt.zpad;

    // leading sign takes one place of the width; a sign after the padding counts with the digits
    always_comb begin
        w_adj    = (lead_sign && r_fmt.width != '0) ? r_fmt.width - 1'b1 : r_fmt.width;
        count    = WD_W'(i_stat.nd) + WD_W'(mid_sign);
        pad_calc = (w_adj > count) ? w_adj - count : '0;
    end

    assign o_take = (r_state == E_DIGIT) && adv;
    assign o_busy = (r_state != E_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= E_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_o_valid <= emit_now;
            end
            unique case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_fmt   <= i_fmt;
                        r_state <= E_WAIT;
                    end
                end
                E_WAIT: begin
                    if (i_stat.done) begin
                        r_pad <= pad_calc;
                        r_nd  <= i_stat.nd;
                        if (lead_sign) begin
                            r_state <= E_LEAD;
                        end else if (pad_calc != '0) begin
                            r_state <= E_PAD;
                        end else if (mid_sign) begin
                            r_state <= E_SIGN;
                        end else begin
                            r_state <= E_DIGIT;
                        end
                    end
                end
                E_LEAD: begin
                    if (adv) begin
                        r_ch      <= CHAR_MINUS;
                        r_last    <= 1'b0;
                        r_state   <= (r_pad != '0) ? E_PAD : E_DIGIT;
                    end
                end
                E_PAD: begin
                    if (adv) begin
                        r_ch      <= r_fmt.zpad ? CHAR_ZERO : CHAR_SPACE;
                        r_last    <= 1'b0;
                        r_pad     <= r_pad - 1'b1;
                        if (r_pad == WD_W'(1)) begin
                            r_state <= mid_sign ? E_SIGN : E_DIGIT;
                        end
                    end
                end
                E_SIGN: begin
                    if (adv) begin
                        r_ch      <= CHAR_MINUS;
                        r_last    <= 1'b0;
                        r_state   <= E_DIGIT;
                    end
                end
                E_DIGIT: begin
                    if (adv) begin
                        r_ch      <= HEX_CHARS[i_stat.digit];
                        r_last    <= (r_nd == ND_W'(1));
                        r_nd      <= r_nd - 1'b1;
                        if (r_nd == ND_W'(1)) begin
                            r_state <= E_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_o_valid;
    assign o_ch    = r_ch;
    assign o_last  = r_last;

    a_take_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> i_stat.done)
        else $error("digit taken before conversion finished");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == E_DIGIT) |-> (r_nd != '0))
        else $error("digit state with no digits left");

    a_pad_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == E_PAD) |-> (r_pad != '0))
        else $error("pad state with no padding left");

    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_nd == ND_W'(1)) |=> (r_state == E_IDLE && o_valid && o_last))
        else $error("final digit did not close the number");

endmodule
